@@ design/n2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types, constants and helpers for the number to ASCII formatter.
// ----------------------------------------------------------------------------
package n2a_pkg;

  localparam int unsigned N2A_CELLS   = 10;
  localparam int unsigned CNT_W       = $clog2(N2A_CELLS + 1);
  localparam int unsigned BCD_DIGITS  = 5;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
  localparam int unsigned BCD_HALF_W  = 12;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef enum logic [2:0] {
    OP_HEX_0X    = 3'd0,
    OP_HEX_X     = 3'd1,
    OP_DEC8_PAD  = 3'd2,
    OP_DEC8_SHORT = 3'd3,
    OP_DEC16     = 3'd4,
    OP_FRAME     = 3'd5
  } n2a_op_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] ch;
    logic       last;
  } n2a_slot_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + ext;
    end
    return CH_A + ext - 8'd10;
  endfunction

  function automatic logic [7:0] dec_char(input logic [3:0] dig);
    return CH_ZERO + {4'h0, dig};
  endfunction

endpackage

@@ design/n2a_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2a_in_if / n2a_out_if
// Valid/ready channels for number words and character words.
// ----------------------------------------------------------------------------
interface n2a_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface n2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

@@ design/n2a_dabble.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2a_dabble
// Eight shift-and-add-3 steps of binary to BCD conversion.
// ----------------------------------------------------------------------------
module n2a_dabble (
  input  logic [n2a_pkg::BCD_W-1:0] bcd_in,
  input  logic [7:0]                bits_in,
  output logic [n2a_pkg::BCD_W-1:0] bcd_out
);

  logic [n2a_pkg::BCD_W-1:0] acc;

  always_comb begin
    acc = bcd_in;
    for (int s = 0; s < 8; s++) begin
      for (int d = 0; d < n2a_pkg::BCD_DIGITS; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[n2a_pkg::BCD_W-2:0], bits_in[7-s]};
    end
    bcd_out = acc;
  end

endmodule

@@ design/n2a_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2a_cell
// One character slot of the output chain; loads or takes its neighbor.
// ----------------------------------------------------------------------------
module n2a_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  n2a_pkg::n2a_slot_t  load_slot,
  input  logic                shift,
  input  n2a_pkg::n2a_slot_t  next_slot,
  output n2a_pkg::n2a_slot_t  slot_q
);

  n2a_pkg::n2a_slot_t slot_r;
  n2a_pkg::n2a_slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = load_slot;
    end else if (shift) begin
      slot_nxt = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_q = slot_r;

endmodule

@@ design/number_to_ascii_formatter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core
// A word is registered in the conversion stage, then loaded into the chain,
// whose first cell offers it. One character per cycle while the output is
// ready; a word has 0 to 10 characters, the next word follows with no gap.
// Rate is set by the ten-cell character chain and its single output port.
// Reset: synchronous, active low; clears the chain and s1_vld_r.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_core (
  input  logic         clk,
  input  logic         rst_n,
  n2a_in_if.sink       in_chan,
  n2a_out_if.source    out_chan
);

  localparam int unsigned N = n2a_pkg::N2A_CELLS;

  logic                               s1_vld_r, s1_vld_nxt;
  logic [2:0]                         s1_op_r;
  logic [31:0]                        s1_val_r;
  logic [n2a_pkg::BCD_HALF_W-1:0]     s1_bcd_r;

  logic [7:0]                         hi_bits;
  logic [n2a_pkg::BCD_W-1:0]          bcd_hi;
  logic [n2a_pkg::BCD_W-1:0]          bcd_full;

  logic                               in_fire, out_fire, load_ok, load;
  logic [7:0]                         chr [N];
  logic [n2a_pkg::CNT_W-1:0]          n_chr;
  n2a_pkg::n2a_slot_t                 load_slot [N];
  n2a_pkg::n2a_slot_t                 chain_q [N+1];

  assign out_fire = chain_q[0].vld && out_chan.ready;
  assign load_ok  = !chain_q[1].vld && (!chain_q[0].vld || out_chan.ready);
  assign load     = s1_vld_r && load_ok;
  assign in_chan.ready = !s1_vld_r || load_ok;
  assign in_fire  = in_chan.valid && in_chan.ready;

  assign hi_bits = (n2a_pkg::n2a_op_t'(in_chan.op) == n2a_pkg::OP_DEC16) ?
                   in_chan.value[15:8] : 8'h00;

  n2a_dabble u_dabble_hi (
    .bcd_in  ('0),
    .bits_in (hi_bits),
    .bcd_out (bcd_hi)
  );

  n2a_dabble u_dabble_lo (
    .bcd_in  ({{(n2a_pkg::BCD_W-n2a_pkg::BCD_HALF_W){1'b0}}, s1_bcd_r}),
    .bits_in (s1_val_r[7:0]),
    .bcd_out (bcd_full)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end else if (load) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_chan.op;
      s1_val_r <= in_chan.value;
      s1_bcd_r <= bcd_hi[n2a_pkg::BCD_HALF_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      chr[i] = 8'h00;
    end
    n_chr = '0;
    case (n2a_pkg::n2a_op_t'(s1_op_r))
      n2a_pkg::OP_HEX_0X: begin
        chr[0] = n2a_pkg::CH_ZERO;
        chr[1] = n2a_pkg::CH_X;
        chr[2] = n2a_pkg::hex_char(s1_val_r[7:4]);
        chr[3] = n2a_pkg::hex_char(s1_val_r[3:0]);
        n_chr  = n2a_pkg::CNT_W'(4);
      end
      n2a_pkg::OP_HEX_X: begin
        chr[0] = n2a_pkg::CH_X;
        chr[1] = n2a_pkg::hex_char(s1_val_r[7:4]);
        chr[2] = n2a_pkg::hex_char(s1_val_r[3:0]);
        n_chr  = n2a_pkg::CNT_W'(3);
      end
      n2a_pkg::OP_DEC8_PAD: begin
        chr[0] = n2a_pkg::dec_char(bcd_full[11:8]);
        chr[1] = n2a_pkg::dec_char(bcd_full[7:4]);
        chr[2] = n2a_pkg::dec_char(bcd_full[3:0]);
        n_chr  = n2a_pkg::CNT_W'(3);
      end
      n2a_pkg::OP_DEC8_SHORT: begin
        if (bcd_full[11:8] != 4'd0) begin
          chr[0] = n2a_pkg::dec_char(bcd_full[11:8]);
          chr[1] = n2a_pkg::dec_char(bcd_full[7:4]);
          chr[2] = n2a_pkg::dec_char(bcd_full[3:0]);
          n_chr  = n2a_pkg::CNT_W'(3);
        end else if (bcd_full[7:4] != 4'd0) begin
          chr[0] = n2a_pkg::dec_char(bcd_full[7:4]);
          chr[1] = n2a_pkg::dec_char(bcd_full[3:0]);
          n_chr  = n2a_pkg::CNT_W'(2);
        end else begin
          chr[0] = n2a_pkg::dec_char(bcd_full[3:0]);
          n_chr  = n2a_pkg::CNT_W'(1);
        end
      end
      n2a_pkg::OP_DEC16: begin
        for (int d = 0; d < n2a_pkg::BCD_DIGITS; d++) begin
          chr[d] = n2a_pkg::dec_char(bcd_full[4*(n2a_pkg::BCD_DIGITS-1-d) +: 4]);
        end
        n_chr = n2a_pkg::CNT_W'(n2a_pkg::BCD_DIGITS);
      end
      n2a_pkg::OP_FRAME: begin
        chr[0] = n2a_pkg::CH_S;
        for (int k = 0; k < 8; k++) begin
          chr[k+1] = n2a_pkg::hex_char(s1_val_r[4*(7-k) +: 4]);
        end
        chr[9] = n2a_pkg::CH_LF;
        n_chr  = n2a_pkg::CNT_W'(10);
      end
      default: begin
        n_chr = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      load_slot[i].vld  = n2a_pkg::CNT_W'(i) < n_chr;
      load_slot[i].ch   = chr[i];
      load_slot[i].last = n2a_pkg::CNT_W'(i + 1) == n_chr;
    end
  end

  assign chain_q[N] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    n2a_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (load),
      .load_slot (load_slot[g]),
      .shift     (out_fire),
      .next_slot (chain_q[g+1]),
      .slot_q    (chain_q[g])
    );
  end

  assign out_chan.valid    = chain_q[0].vld;
  assign out_chan.char_out = chain_q[0].ch;
  assign out_chan.last     = chain_q[0].last;

endmodule
